@@ src/fbde_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// fbde_pkg
// Shared types and constants of the 4bpp frame store draw engine.
// ----------------------------------------------------------------------------
package fbde_pkg;

	// field widths
	localparam int OP_W      = 3;
	localparam int COORD_W   = 12;
	localparam int PX_W      = COORD_W + 1;
	localparam int LVL_W     = 4;
	localparam int SPAN_W    = 10;
	localparam int FMT_W     = 2;
	localparam int DATA_W    = 8;
	localparam int RADDR_W   = 13;
	localparam int BW_W      = 9;
	localparam int BH_W      = 7;
	localparam int IDX_W     = 16;
	localparam int CFG_IDX_W = 2;

	typedef logic [BW_W-1:0]          bwidth_t;
	typedef logic [BH_W-1:0]          bheight_t;
	typedef logic signed [PX_W-1:0]   pxcoord_t;
	typedef logic [IDX_W-1:0]         idx_t;

	// opcodes
	localparam logic [OP_W-1:0] OP_FILL = 3'd0;
	localparam logic [OP_W-1:0] OP_PLOT = 3'd1;
	localparam logic [OP_W-1:0] OP_OPEN = 3'd2;
	localparam logic [OP_W-1:0] OP_DATA = 3'd3;
	localparam logic [OP_W-1:0] OP_READ = 3'd4;

	// region source formats
	localparam logic [FMT_W-1:0] FMT_GLYPH   = 2'd0;
	localparam logic [FMT_W-1:0] FMT_PACKED4 = 2'd1;
	localparam logic [FMT_W-1:0] FMT_BYTE8   = 2'd2;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_BUFFER_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_BUFFER_HEIGHT = 2'd1;

	localparam bwidth_t  BW_RESET = 9'd256;
	localparam bheight_t BH_RESET = 7'd64;

	localparam logic [DATA_W-1:0] NIB_HI_MASK = 8'hF0;
	localparam logic [DATA_W-1:0] NIB_LO_MASK = 8'h0F;

	// pixel location after clipping
	typedef struct packed {
		logic hit;
		logic odd;
		idx_t idx;
	} pix_loc_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_FILL_SIZE,
		ST_FILL,
		ST_RG_NEXT,
		ST_PX_ADDR,
		ST_PX_READ,
		ST_PX_WRITE,
		ST_RD_MEM,
		ST_RD_OUT
	} state_t;

endpackage
`default_nettype wire

@@ src/fbde_pix_addr.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// fbde_pix_addr
// Clips a signed pixel coordinate and registers its byte index and nibble.
// ----------------------------------------------------------------------------
module fbde_pix_addr #(
	parameter int STORE_BYTES = 8192
) (
	input  wire logic               clk,
	input  wire fbde_pkg::pxcoord_t x,
	input  wire fbde_pkg::pxcoord_t y,
	input  wire fbde_pkg::bwidth_t  width,
	input  wire fbde_pkg::bheight_t height,
	output fbde_pkg::pix_loc_t      loc
);

	localparam int XW = fbde_pkg::PX_W - 1;
	localparam int LW = fbde_pkg::IDX_W + 1;

	logic               x_in;
	logic               y_in;
	logic [LW-1:0]      lin;
	fbde_pkg::pix_loc_t loc_d;

	always_comb begin
		x_in = !x[fbde_pkg::PX_W-1] && (x[XW-1:0] < XW'(width));
		y_in = !y[fbde_pkg::PX_W-1] && (y[XW-1:0] < XW'(height));
		// only meaningful when both coordinates are inside the frame
		lin = LW'(y[fbde_pkg::BH_W-1:0]) * LW'(width) + LW'(x[fbde_pkg::BW_W-1:0]);
		loc_d.idx = lin[LW-1:1];
		loc_d.odd = lin[0];
		loc_d.hit = x_in && y_in && (32'(lin[LW-1:1]) < STORE_BYTES);
	end

	always_ff @(posedge clk) begin
		loc <= loc_d;
	end

endmodule
`default_nettype wire

@@ src/framebuffer_4bpp_draw_engine_top.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// framebuffer_4bpp_draw_engine_top
// 4bpp frame store with fill, clipped plot, region blit and byte read.
// ----------------------------------------------------------------------------
// one item at a time, paced by read-modify-write on the single frame memory;
// an open or ignored beat only updates registers; a plot reads its byte and writes
// it back, or nothing when clipped; a fill sweeps (width*height)/2 bytes; a read
// registers the byte, then loads a result that waits on m_axis_tready; a region
// byte plots each of its drawn pixels; arst_n resets control, config and region
// state; frame memory is not cleared and holds garbage until written
// ----------------------------------------------------------------------------
module framebuffer_4bpp_draw_engine_top #(
	parameter int MAX_WIDTH  = 256,
	parameter int MAX_HEIGHT = 64
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// input stream
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	// x_coord[11:0], y_coord[23:12], brightness[27:24], region_width[37:28],
	// region_height[47:38], pixel_format[49:48], data_byte[57:50],
	// read_address[70:58], zero pad[71]
	input  wire logic [71:0] s_axis_tdata,
	// opcode[2:0]
	input  wire logic [2:0]  s_axis_tuser,
	// result stream
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	// read_data[7:0], read_index[20:8], zero pad[23:21]
	output logic [23:0]      m_axis_tdata,
	// configuration writes
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [8:0]  cfg_data
);

	localparam int STORE_BYTES = (MAX_WIDTH * MAX_HEIGHT) / 2;
	localparam int AW          = (STORE_BYTES > 1) ? $clog2(STORE_BYTES) : 1;
	localparam int CW          = fbde_pkg::SPAN_W + 1;

	// input fields
	logic [fbde_pkg::OP_W-1:0]    in_op;
	logic [fbde_pkg::COORD_W-1:0] in_x;
	logic [fbde_pkg::COORD_W-1:0] in_y;
	logic [fbde_pkg::LVL_W-1:0]   in_lvl;
	logic [fbde_pkg::SPAN_W-1:0]  in_rw;
	logic [fbde_pkg::SPAN_W-1:0]  in_rh;
	logic [fbde_pkg::FMT_W-1:0]   in_fmt;
	logic [fbde_pkg::DATA_W-1:0]  in_db;
	logic [fbde_pkg::RADDR_W-1:0] in_ra;

	assign in_op  = s_axis_tuser;
	assign in_x   = s_axis_tdata[11:0];
	assign in_y   = s_axis_tdata[23:12];
	assign in_lvl = s_axis_tdata[27:24];
	assign in_rw  = s_axis_tdata[37:28];
	assign in_rh  = s_axis_tdata[47:38];
	assign in_fmt = s_axis_tdata[49:48];
	assign in_db  = s_axis_tdata[57:50];
	assign in_ra  = s_axis_tdata[70:58];

	fbde_pkg::state_t state_q, state_d;

	// configuration and region state
	fbde_pkg::bwidth_t                   bw_q;
	fbde_pkg::bheight_t                  bh_q;
	logic signed [fbde_pkg::COORD_W-1:0] origin_col_q;
	logic signed [fbde_pkg::COORD_W-1:0] origin_row_q;
	logic [fbde_pkg::SPAN_W-1:0]         span_w_q;
	logic [fbde_pkg::SPAN_W-1:0]         span_h_q;
	logic [fbde_pkg::SPAN_W-1:0]         cur_col_q;
	logic [fbde_pkg::SPAN_W-1:0]         cur_row_q;
	logic [fbde_pkg::FMT_W-1:0]          fmt_q;
	logic [fbde_pkg::LVL_W-1:0]          ink_q;

	// working registers
	logic [fbde_pkg::DATA_W-1:0]  shift_q;
	logic [3:0]                   left_q;
	fbde_pkg::pxcoord_t           px_x_q;
	fbde_pkg::pxcoord_t           px_y_q;
	logic [fbde_pkg::LVL_W-1:0]   px_lvl_q;
	logic                         in_region_q;
	logic [fbde_pkg::LVL_W-1:0]   fill_lvl_q;
	fbde_pkg::idx_t               fill_n_q;
	fbde_pkg::idx_t               fill_cnt_q;
	logic [fbde_pkg::RADDR_W-1:0] rd_addr_q;
	logic                         rd_hit_q;
	logic [fbde_pkg::DATA_W-1:0]  rdata_q;
	logic                         out_valid_q;
	logic [fbde_pkg::DATA_W-1:0]  out_data_q;
	logic [fbde_pkg::RADDR_W-1:0] out_index_q;

	// frame memory port
	logic                        mem_we;
	logic [AW-1:0]               mem_waddr;
	logic [fbde_pkg::DATA_W-1:0] mem_wdata;
	logic                        mem_re;
	logic [AW-1:0]               mem_raddr;
	logic [fbde_pkg::DATA_W-1:0] mem_q [0:STORE_BYTES-1];

	fbde_pkg::bwidth_t  eff_w;
	fbde_pkg::bheight_t eff_h;
	fbde_pkg::idx_t     fill_half;
	fbde_pkg::idx_t     fill_n_d;
	fbde_pkg::pix_loc_t pix_loc;
	logic               rg_live;
	logic               rg_step;
	logic               draw_bit;
	logic               fmt_ok;
	logic               accept;
	logic               out_load;

	assign s_axis_tready = (state_q == fbde_pkg::ST_IDLE);
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign cfg_ready     = 1'b1;
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {3'b000, out_index_q, out_data_q};

	always_comb begin
		eff_w = (32'(bw_q) > MAX_WIDTH) ? fbde_pkg::bwidth_t'(MAX_WIDTH) : bw_q;
		eff_h = (32'(bh_q) > MAX_HEIGHT) ? fbde_pkg::bheight_t'(MAX_HEIGHT) : bh_q;
		fill_half = fbde_pkg::idx_t'((fbde_pkg::IDX_W'(eff_w) * fbde_pkg::IDX_W'(eff_h)) >> 1);
		fill_n_d  = (32'(fill_half) > STORE_BYTES) ? fbde_pkg::idx_t'(STORE_BYTES) : fill_half;
		rg_live  = (span_w_q != '0) && (cur_row_q < span_h_q);
		rg_step  = (state_q == fbde_pkg::ST_RG_NEXT) && (left_q != '0) && rg_live;
		draw_bit = (fmt_q != fbde_pkg::FMT_GLYPH) || shift_q[fbde_pkg::DATA_W-1];
		fmt_ok   = (fmt_q == fbde_pkg::FMT_GLYPH) || (fmt_q == fbde_pkg::FMT_PACKED4)
			|| (fmt_q == fbde_pkg::FMT_BYTE8);
		out_load = (state_q == fbde_pkg::ST_RD_OUT) && (!out_valid_q || m_axis_tready);
	end

	fbde_pix_addr #(
		.STORE_BYTES(STORE_BYTES)
	) u_pix_addr (
		.clk   (clk),
		.x     (px_x_q),
		.y     (px_y_q),
		.width (eff_w),
		.height(eff_h),
		.loc   (pix_loc)
	);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= fbde_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		mem_we    = 1'b0;
		mem_waddr = '0;
		mem_wdata = '0;
		mem_re    = 1'b0;
		mem_raddr = '0;
		unique case (state_q)
			fbde_pkg::ST_IDLE: begin
				if (s_axis_tvalid) begin
					unique case (in_op)
						fbde_pkg::OP_FILL: state_d = fbde_pkg::ST_FILL_SIZE;
						fbde_pkg::OP_PLOT: state_d = fbde_pkg::ST_PX_ADDR;
						fbde_pkg::OP_DATA: begin
							if (span_w_q != '0 && span_h_q != '0 && fmt_ok) begin
								state_d = fbde_pkg::ST_RG_NEXT;
							end
						end
						fbde_pkg::OP_READ: state_d = fbde_pkg::ST_RD_MEM;
						default: state_d = fbde_pkg::ST_IDLE;
					endcase
				end
			end
			fbde_pkg::ST_FILL_SIZE: state_d = fbde_pkg::ST_FILL;
			fbde_pkg::ST_FILL: begin
				if (fill_cnt_q < fill_n_q) begin
					mem_we    = 1'b1;
					mem_waddr = AW'(fill_cnt_q);
					mem_wdata = {fill_lvl_q, fill_lvl_q};
				end else begin
					state_d = fbde_pkg::ST_IDLE;
				end
			end
			fbde_pkg::ST_RG_NEXT: begin
				if (!rg_step) begin
					state_d = fbde_pkg::ST_IDLE;
				end else if (draw_bit) begin
					state_d = fbde_pkg::ST_PX_ADDR;
				end
			end
			fbde_pkg::ST_PX_ADDR: state_d = fbde_pkg::ST_PX_READ;
			fbde_pkg::ST_PX_READ: begin
				if (pix_loc.hit) begin
					mem_re    = 1'b1;
					mem_raddr = AW'(pix_loc.idx);
					state_d   = fbde_pkg::ST_PX_WRITE;
				end else begin
					state_d = in_region_q ? fbde_pkg::ST_RG_NEXT : fbde_pkg::ST_IDLE;
				end
			end
			fbde_pkg::ST_PX_WRITE: begin
				mem_we    = 1'b1;
				mem_waddr = AW'(pix_loc.idx);
				// odd pixel lives in the low nibble
				if (pix_loc.odd) begin
					mem_wdata = (rdata_q & fbde_pkg::NIB_HI_MASK) | {4'b0000, px_lvl_q};
				end else begin
					mem_wdata = (rdata_q & fbde_pkg::NIB_LO_MASK) | {px_lvl_q, 4'b0000};
				end
				state_d = in_region_q ? fbde_pkg::ST_RG_NEXT : fbde_pkg::ST_IDLE;
			end
			fbde_pkg::ST_RD_MEM: begin
				mem_re    = rd_hit_q;
				mem_raddr = AW'(rd_addr_q);
				state_d   = fbde_pkg::ST_RD_OUT;
			end
			fbde_pkg::ST_RD_OUT: begin
				if (out_load) begin
					state_d = fbde_pkg::ST_IDLE;
				end
			end
			default: state_d = fbde_pkg::ST_IDLE;
		endcase
	end

	// frame memory, one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem_q[mem_waddr] <= mem_wdata;
		end
		if (mem_re) begin
			rdata_q <= mem_q[mem_raddr];
		end
	end

	// configuration, region state and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bw_q         <= fbde_pkg::BW_RESET;
			bh_q         <= fbde_pkg::BH_RESET;
			origin_col_q <= '0;
			origin_row_q <= '0;
			span_w_q     <= '0;
			span_h_q     <= '0;
			cur_col_q    <= '0;
			cur_row_q    <= '0;
			fmt_q        <= '0;
			ink_q        <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == fbde_pkg::REG_BUFFER_WIDTH) begin
					bw_q <= cfg_data;
				end else if (cfg_index == fbde_pkg::REG_BUFFER_HEIGHT) begin
					bh_q <= cfg_data[fbde_pkg::BH_W-1:0];
				end
			end
			if (accept && in_op == fbde_pkg::OP_OPEN) begin
				origin_col_q <= in_x;
				origin_row_q <= in_y;
				span_w_q     <= in_rw;
				span_h_q     <= in_rh;
				fmt_q        <= in_fmt;
				ink_q        <= in_lvl;
				cur_col_q    <= '0;
				cur_row_q    <= '0;
			end
			if (rg_step) begin
				if (CW'(cur_col_q) + CW'(1) >= CW'(span_w_q)) begin
					cur_col_q <= '0;
					cur_row_q <= cur_row_q + 1'b1;
				end else begin
					cur_col_q <= cur_col_q + 1'b1;
				end
			end
			if (m_axis_tvalid && m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end
		end
	end

	// working payload
	always_ff @(posedge clk) begin
		if (accept) begin
			unique case (in_op)
				fbde_pkg::OP_FILL: fill_lvl_q <= in_lvl;
				fbde_pkg::OP_PLOT: begin
					px_x_q      <= {in_x[fbde_pkg::COORD_W-1], in_x};
					px_y_q      <= {in_y[fbde_pkg::COORD_W-1], in_y};
					px_lvl_q    <= in_lvl;
					in_region_q <= 1'b0;
				end
				fbde_pkg::OP_DATA: begin
					shift_q     <= in_db;
					in_region_q <= 1'b1;
					if (fmt_q == fbde_pkg::FMT_GLYPH) begin
						left_q <= 4'd8;
					end else if (fmt_q == fbde_pkg::FMT_PACKED4) begin
						left_q <= 4'd2;
					end else begin
						left_q <= 4'd1;
					end
				end
				fbde_pkg::OP_READ: begin
					rd_addr_q <= in_ra;
					rd_hit_q  <= (32'(in_ra) < STORE_BYTES);
				end
				default: ;
			endcase
		end
		if (state_q == fbde_pkg::ST_FILL_SIZE) begin
			fill_n_q   <= fill_n_d;
			fill_cnt_q <= '0;
		end
		if (state_q == fbde_pkg::ST_FILL && fill_cnt_q < fill_n_q) begin
			fill_cnt_q <= fill_cnt_q + 1'b1;
		end
		if (rg_step) begin
			px_x_q <= $signed({origin_col_q[fbde_pkg::COORD_W-1], origin_col_q})
				+ $signed({3'b000, cur_col_q});
			px_y_q <= $signed({origin_row_q[fbde_pkg::COORD_W-1], origin_row_q})
				+ $signed({3'b000, cur_row_q});
			left_q <= left_q - 1'b1;
			if (fmt_q == fbde_pkg::FMT_GLYPH) begin
				px_lvl_q <= ink_q;
				shift_q  <= shift_q << 1;
			end else begin
				px_lvl_q <= shift_q[7:4];
				shift_q  <= shift_q << 4;
			end
		end
		if (out_load) begin
			out_data_q  <= rd_hit_q ? rdata_q : '0;
			out_index_q <= rd_addr_q;
		end
	end

`ifndef SYNTHESIS
	// frame store is written only by a fill sweep or the write half of a plot or region pixel
	assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> (state_q == fbde_pkg::ST_FILL || state_q == fbde_pkg::ST_PX_WRITE))
		else $error("frame store write outside fill or pixel write");

	// a pixel write always follows its own read of the same byte
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == fbde_pkg::ST_PX_WRITE) |-> ($past(state_q) == fbde_pkg::ST_PX_READ
			&& $past(mem_re) && $past(mem_raddr) == mem_waddr))
		else $error("pixel write without matching read");

	// a new result beat only comes out of the read sequence
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> ($past(state_q) == fbde_pkg::ST_RD_OUT))
		else $error("result beat without a read");

	// region cursor never runs past the region end
	assert property (@(posedge clk) disable iff (!arst_n)
		cur_row_q <= span_h_q)
		else $error("region cursor past last row");
`endif

endmodule
`default_nettype wire
